@@ design/rgbycc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbycc_pkg: shared types and constants
// BT.601 full-range weights in 8-bit fixed point, pixel type and widths
// for the 2x2 RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgbycc_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CompW     = 8;
  localparam int unsigned LumaAccW  = 16;  // 256*255 + 128 fits in 16 bits
  localparam int unsigned SumW      = 10;  // four 8-bit values
  localparam int unsigned ChromaAccW = 18; // biased chroma sum stays below 2**18

  // luma weights, FIX(0.299) FIX(0.587) FIX(0.114), rounding one half
  localparam logic [7:0] LumaR     = 8'd77;
  localparam logic [7:0] LumaG     = 8'd150;
  localparam logic [7:0] LumaB     = 8'd29;
  localparam logic [7:0] LumaRound = 8'd128;

  // chroma weights on four-pixel sums, magnitudes
  localparam logic [7:0] CbR = 8'd43;   // FIX(0.16874)
  localparam logic [7:0] CbG = 8'd85;   // FIX(0.33126)
  localparam logic [7:0] CbB = 8'd128;  // FIX(0.5)
  localparam logic [7:0] CrR = 8'd128;  // FIX(0.5)
  localparam logic [7:0] CrG = 8'd107;  // FIX(0.41869)
  localparam logic [7:0] CrB = 8'd21;   // FIX(0.08131)

  // rounding 511 plus the 128 offset folded in above the 10-bit shift
  localparam logic [ChromaAccW-1:0] ChromaBias = 18'd131583;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } pixel_t;

endpackage

@@ design/rgbycc_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbycc_lane: one pixel lane
// Computes the luma of one pixel and registers it together with the pixel
// for the merge stage.
// ----------------------------------------------------------------------------
module rgbycc_lane (
  input  logic                                clk,
  input  logic                                load,
  input  rgbycc_pkg::pixel_t                  pixel,
  output logic [rgbycc_pkg::CompW-1:0]        luma,
  output rgbycc_pkg::pixel_t                  pixel_held
);

  logic [rgbycc_pkg::LumaAccW-1:0] luma_acc;

  assign luma_acc = rgbycc_pkg::LumaAccW'(pixel.red)   * rgbycc_pkg::LumaR
                  + rgbycc_pkg::LumaAccW'(pixel.green) * rgbycc_pkg::LumaG
                  + rgbycc_pkg::LumaAccW'(pixel.blue)  * rgbycc_pkg::LumaB
                  + rgbycc_pkg::LumaAccW'(rgbycc_pkg::LumaRound);

  always_ff @(posedge clk) begin
    if (load) begin
      luma       <= luma_acc[rgbycc_pkg::LumaAccW-1 -: rgbycc_pkg::CompW];
      pixel_held <= pixel;
    end
  end

endmodule

@@ design/rgbycc_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbycc_merge: merge stage
// Sums the four lane pixels, derives the shared Cb and Cr and registers
// the complete result item.
// ----------------------------------------------------------------------------
module rgbycc_merge (
  input  logic                         clk,
  input  logic                         load,
  input  rgbycc_pkg::pixel_t           pixels [rgbycc_pkg::NumLanes],
  input  logic [rgbycc_pkg::CompW-1:0] lumas  [rgbycc_pkg::NumLanes],
  output logic [rgbycc_pkg::CompW-1:0] luma_out [rgbycc_pkg::NumLanes],
  output logic [rgbycc_pkg::CompW-1:0] cb_out,
  output logic [rgbycc_pkg::CompW-1:0] cr_out
);

  localparam int unsigned AccW = rgbycc_pkg::ChromaAccW;

  logic [rgbycc_pkg::SumW-1:0] red_sum, green_sum, blue_sum;
  logic [AccW-1:0]             cb_acc, cr_acc;

  always_comb begin
    red_sum   = '0;
    green_sum = '0;
    blue_sum  = '0;
    for (int i = 0; i < rgbycc_pkg::NumLanes; i++) begin
      red_sum   = red_sum   + rgbycc_pkg::SumW'(pixels[i].red);
      green_sum = green_sum + rgbycc_pkg::SumW'(pixels[i].green);
      blue_sum  = blue_sum  + rgbycc_pkg::SumW'(pixels[i].blue);
    end
  end

  // negative terms subtract modulo 2**AccW; the true result is never negative
  assign cb_acc = AccW'(blue_sum) * rgbycc_pkg::CbB + rgbycc_pkg::ChromaBias
                - AccW'(red_sum) * rgbycc_pkg::CbR - AccW'(green_sum) * rgbycc_pkg::CbG;
  assign cr_acc = AccW'(red_sum) * rgbycc_pkg::CrR + rgbycc_pkg::ChromaBias
                - AccW'(green_sum) * rgbycc_pkg::CrG - AccW'(blue_sum) * rgbycc_pkg::CrB;

  always_ff @(posedge clk) begin
    if (load) begin
      luma_out <= lumas;
      cb_out   <= cb_acc[AccW-1 -: rgbycc_pkg::CompW];
      cr_out   <= cr_acc[AccW-1 -: rgbycc_pkg::CompW];
    end
  end

endmodule

@@ design/rgb_to_ycbcr_420_block.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_420_block: 2x2 RGB block to YCbCr 4:2:0 converter
// BT.601 full-range conversion of one 2x2 pixel block per item: four luma
// values and one shared Cb/Cr pair.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  pixel    | pixel_valid / pixel_stall  | red_/green_/blue_ x four positions
//  result   | result_valid / result_stall| luma_ x four, chroma_blue/red
//
//  one item per cycle sustained while result_stall stays low; an item passes
//  through the lane register stage and then the merge register stage
//  rst (synchronous, active high) empties both stages
//  a stalled result holds in the merge stage while the lane stage still
//  takes one more item; pixel_stall rises only when both stages are full
//
module rgb_to_ycbcr_420_block (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] red_top_left,
  input  logic [7:0] green_top_left,
  input  logic [7:0] blue_top_left,
  input  logic [7:0] red_top_right,
  input  logic [7:0] green_top_right,
  input  logic [7:0] blue_top_right,
  input  logic [7:0] red_bottom_left,
  input  logic [7:0] green_bottom_left,
  input  logic [7:0] blue_bottom_left,
  input  logic [7:0] red_bottom_right,
  input  logic [7:0] green_bottom_right,
  input  logic [7:0] blue_bottom_right,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] luma_top_left,
  output logic [7:0] luma_top_right,
  output logic [7:0] luma_bottom_left,
  output logic [7:0] luma_bottom_right,
  output logic [7:0] chroma_blue,
  output logic [7:0] chroma_red
);

  localparam int unsigned Lanes = rgbycc_pkg::NumLanes;

  rgbycc_pkg::pixel_t             pixel_in   [Lanes];
  rgbycc_pkg::pixel_t             pixel_held [Lanes];
  logic [rgbycc_pkg::CompW-1:0]   lane_luma  [Lanes];
  logic [rgbycc_pkg::CompW-1:0]   merge_luma [Lanes];

  // stage occupancy
  logic lane_valid;
  logic merge_advance;
  logic lane_advance;

  // lane order: top-left, top-right, bottom-left, bottom-right
  assign pixel_in[0] = '{red: red_top_left,     green: green_top_left,
                         blue: blue_top_left};
  assign pixel_in[1] = '{red: red_top_right,    green: green_top_right,
                         blue: blue_top_right};
  assign pixel_in[2] = '{red: red_bottom_left,  green: green_bottom_left,
                         blue: blue_bottom_left};
  assign pixel_in[3] = '{red: red_bottom_right, green: green_bottom_right,
                         blue: blue_bottom_right};

  // merge stage moves when empty or when its result is being taken
  assign merge_advance = !result_valid || !result_stall;
  // lane stage moves when empty or when it hands over to the merge stage
  assign lane_advance  = !lane_valid || merge_advance;
  assign pixel_stall   = !lane_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (lane_advance) begin
        lane_valid <= pixel_valid;
      end
      if (merge_advance) begin
        result_valid <= lane_valid;
      end
    end
  end

  // one luma lane per pixel of the block
  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    rgbycc_lane u_lane (
      .clk        (clk),
      .load       (lane_advance && pixel_valid),
      .pixel      (pixel_in[i]),
      .luma       (lane_luma[i]),
      .pixel_held (pixel_held[i])
    );
  end

  // chroma from the block sums, result register
  rgbycc_merge u_merge (
    .clk      (clk),
    .load     (merge_advance && lane_valid),
    .pixels   (pixel_held),
    .lumas    (lane_luma),
    .luma_out (merge_luma),
    .cb_out   (chroma_blue),
    .cr_out   (chroma_red)
  );

  assign luma_top_left     = merge_luma[0];
  assign luma_top_right    = merge_luma[1];
  assign luma_bottom_left  = merge_luma[2];
  assign luma_bottom_right = merge_luma[3];

  // input is held back only while both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (lane_valid && result_valid && result_stall))
    else $error("pixel_stall with a free stage");

  // a lane item that hands over always shows up as a result
  a_lane_to_result: assert property (@(posedge clk) disable iff (rst)
    (lane_valid && merge_advance) |=> result_valid)
    else $error("lane item lost at merge stage");

  // an accepted item always occupies the lane stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> lane_valid)
    else $error("accepted item not held in lane stage");

  // taking the last result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !lane_valid) |=> !result_valid)
    else $error("result repeated after being taken");

endmodule
